@@ hw/rtl/kvfe_pkg.sv @@
// Shared types and constants for the key/value field extractor.
package kvfe_pkg;

  // Default for the label capacity (bytes) of the top level.
  localparam int unsigned MAX_LABEL_BYTES_DEF = 16;

  // Fixed field and port widths.
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  // Result queue geometry.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QP_W   = 2;
  localparam int unsigned QC_W   = 3;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2
  } status_t;

  // What one accepted byte produces: an optional value byte, then an
  // optional status.
  typedef struct packed {
    logic               val_vld;
    logic [BYTE_W-1:0]  val_byte;
    logic               st_vld;
    status_t            st_code;
  } scan_res_t;

  // One result word as it sits in the output queue.
  typedef struct packed {
    logic [BYTE_W-1:0]  value_byte;
    logic               is_status;
    status_t            code;
    logic               run_last;
  } res_word_t;

endpackage

@@ hw/rtl/kvfe_scan.sv @@
// Label registers and per-byte scanner state for the key/value extractor.
module kvfe_scan #(
  parameter int unsigned MAX_LABEL_BYTES = kvfe_pkg::MAX_LABEL_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_acc,
  input  logic [kvfe_pkg::BYTE_W-1:0]         in_byte,
  input  logic                                in_end,
  input  logic                                cfg_we,
  input  logic [kvfe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [kvfe_pkg::CFG_DATA_W-1:0]     cfg_data,
  output kvfe_pkg::scan_res_t                 res
);

  localparam int unsigned CNT_W = $clog2(MAX_LABEL_BYTES + 1);
  localparam int unsigned IDX_W = (MAX_LABEL_BYTES > 1) ? $clog2(MAX_LABEL_BYTES) : 1;
  localparam int unsigned BW    = kvfe_pkg::BYTE_W;
  localparam int unsigned LW    = kvfe_pkg::LEN_W;

  localparam logic [kvfe_pkg::CFG_IDX_W-1:0] REG_LABEL_LO  = 2'd0;
  localparam logic [kvfe_pkg::CFG_IDX_W-1:0] REG_LABEL_HI  = 2'd1;
  localparam logic [kvfe_pkg::CFG_IDX_W-1:0] REG_LABEL_LEN = 2'd2;

  localparam logic [BW-1:0] CH_TAB   = 8'h09;
  localparam logic [BW-1:0] CH_LF    = 8'h0a;
  localparam logic [BW-1:0] CH_CR    = 8'h0d;
  localparam logic [BW-1:0] CH_SPACE = 8'h20;
  localparam logic [BW-1:0] CH_QUOTE = 8'h22;
  localparam logic [BW-1:0] CH_EQUAL = 8'h3d;

  typedef enum logic [2:0] {
    PH_SEARCH    = 3'd0,
    PH_BEFORE_EQ = 3'd1,
    PH_SKIP      = 3'd2,
    PH_QUOTED    = 3'd3,
    PH_WORD      = 3'd4,
    PH_DONE      = 3'd5
  } phase_t;

  logic [BW-1:0]    label_r [MAX_LABEL_BYTES];
  logic [LW-1:0]    len_r;

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             prevq_r, prevq_nxt;
  logic             lao_r, lao_nxt;
  logic             seen_r, seen_nxt;

  // Label bytes: only bytes below the capacity are kept.
  for (genvar gi = 0; gi < MAX_LABEL_BYTES; gi++) begin : g_lab
    localparam int unsigned BI = gi % 8;
    localparam logic [kvfe_pkg::CFG_IDX_W-1:0] SEL = (gi / 8 == 0) ? REG_LABEL_LO : REG_LABEL_HI;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        label_r[gi] <= '0;
      end else if (cfg_we && cfg_index == SEL) begin
        label_r[gi] <= cfg_data[BI*BW +: BW];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LW'(1);
    end else if (cfg_we && cfg_index == REG_LABEL_LEN) begin
      len_r <= cfg_data[LW-1:0];
    end
  end

  // Effective length, clamped to 1..capacity.
  logic [LW-1:0]    len_clamp;
  logic [CNT_W-1:0] len_eff;
  always_comb begin
    if (len_r == '0) begin
      len_clamp = LW'(1);
    end else if (len_r > LW'(MAX_LABEL_BYTES)) begin
      len_clamp = LW'(MAX_LABEL_BYTES);
    end else begin
      len_clamp = len_r;
    end
    len_eff = CNT_W'(len_clamp);
  end

  // Label match step; a mismatch retries the byte against label byte 0.
  logic [CNT_W-1:0] c0, c1, c2, s_cnt;
  logic             eq_c, eq_0, hit, s_done, s_lao;
  always_comb begin
    c0     = (cnt_r >= len_eff) ? '0 : cnt_r;
    eq_c   = (in_byte == label_r[c0[IDX_W-1:0]]);
    eq_0   = (in_byte == label_r[0]);
    hit    = eq_c || eq_0;
    c1     = eq_c ? c0 : '0;
    c2     = c1 + CNT_W'(1);
    s_lao  = (hit && c1 == '0) ? prevq_r : lao_r;
    s_done = hit && (c2 >= len_eff);
    s_cnt  = (!hit || s_done) ? '0 : c2;
  end

  logic is_blank, is_eol, is_quote;
  assign is_blank = (in_byte == CH_SPACE) || (in_byte == CH_TAB);
  assign is_eol   = (in_byte == CH_LF) || (in_byte == CH_CR);
  assign is_quote = (in_byte == CH_QUOTE);

  logic              due, emit;
  kvfe_pkg::status_t code;
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    prevq_nxt = prevq_r;
    lao_nxt   = lao_r;
    seen_nxt  = seen_r;
    due       = 1'b0;
    emit      = 1'b0;
    code      = kvfe_pkg::ST_FOUND;
    if (phase_r != PH_DONE) begin
      if (in_byte == '0) begin
        due = 1'b1;
      end else begin
        seen_nxt = 1'b1;
        case (phase_r)
          PH_SEARCH: begin
            cnt_nxt = s_cnt;
            lao_nxt = s_lao;
            if (s_done) phase_nxt = PH_BEFORE_EQ;
          end
          PH_BEFORE_EQ: begin
            if (in_byte == CH_EQUAL) begin
              phase_nxt = PH_SKIP;
            end else if (!is_blank) begin
              cnt_nxt   = s_cnt;
              lao_nxt   = s_lao;
              phase_nxt = s_done ? PH_BEFORE_EQ : PH_SEARCH;
            end
          end
          PH_SKIP: begin
            if (is_blank) begin
              phase_nxt = PH_SKIP;
            end else if (is_quote) begin
              phase_nxt = PH_QUOTED;
            end else if (lao_r) begin
              phase_nxt = PH_QUOTED;
              emit      = 1'b1;
            end else begin
              phase_nxt = PH_WORD;
              if (is_eol) due = 1'b1;
              else        emit = 1'b1;
            end
          end
          PH_QUOTED: begin
            if (is_quote) due = 1'b1;
            else          emit = 1'b1;
          end
          PH_WORD: begin
            if (is_blank || is_eol) due = 1'b1;
            else                    emit = 1'b1;
          end
          default: begin
          end
        endcase
        prevq_nxt = is_quote;
      end
      if (in_end) due = 1'b1;
      if (due) begin
        if (phase_nxt == PH_SKIP || phase_nxt == PH_QUOTED || phase_nxt == PH_WORD) begin
          code = kvfe_pkg::ST_FOUND;
        end else if (seen_nxt) begin
          code = kvfe_pkg::ST_NOT_FOUND;
        end else begin
          code = kvfe_pkg::ST_EMPTY;
        end
        phase_nxt = PH_DONE;
      end
    end
    // New line starts from scratch.
    if (in_end) begin
      phase_nxt = PH_SEARCH;
      cnt_nxt   = '0;
      prevq_nxt = 1'b0;
      lao_nxt   = 1'b0;
      seen_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEARCH;
      cnt_r   <= '0;
      prevq_r <= 1'b0;
      lao_r   <= 1'b0;
      seen_r  <= 1'b0;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      prevq_r <= prevq_nxt;
      lao_r   <= lao_nxt;
      seen_r  <= seen_nxt;
    end
  end

  assign res.val_vld  = emit;
  assign res.val_byte = in_byte;
  assign res.st_vld   = due;
  assign res.st_code  = code;

endmodule

@@ hw/rtl/key_value_field_extractor.sv @@
// Top level of the key/value field extractor: scanner plus result queue.
//
// Takes a command line one byte per word and looks for the label held in
// the label registers (1 to MAX_LABEL_BYTES bytes; a length of 0 acts as 1,
// larger than the capacity acts as the capacity). After the label, optional
// blanks and '=' must follow; blanks after '=' are skipped and the value
// bytes come out one per result word. A value is quoted when it opens with
// '"' or when the byte in front of the label was '"'; quoted values run to
// the closing quote, others to a blank, LF, CR or zero byte. Each line ends
// with exactly one status word: found, not found or empty line, given at
// the zero byte, at the end of the value, or at the byte flagged line_end.
// Every input word is decided in the cycle it is accepted; its zero, one or
// two result words go into a 4-word output queue. The block takes one byte
// per cycle while in_stall is low. A byte with both a value byte and a
// status puts two words in the queue, drained one at a time by the single
// output port; in_stall rises only while fewer than two queue slots are
// free. Configuration is written through cfg_we/cfg_index/cfg_data; the
// user must write it only while idle, and the block does not enforce this.
module key_value_field_extractor #(
  parameter int unsigned MAX_LABEL_BYTES = kvfe_pkg::MAX_LABEL_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input words
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [kvfe_pkg::BYTE_W-1:0]      in_line_byte,
  input  logic                             in_line_end,
  // result words
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [kvfe_pkg::BYTE_W-1:0]      out_value_byte,
  output logic                             out_is_status,
  output logic [1:0]                       out_status_code,
  output logic                             out_run_last,
  // configuration writes
  input  logic                             cfg_we,
  input  logic [kvfe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kvfe_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned QDEPTH = kvfe_pkg::QDEPTH;
  localparam int unsigned QP_W   = kvfe_pkg::QP_W;
  localparam int unsigned QC_W   = kvfe_pkg::QC_W;

  logic                in_acc;
  logic                pop;
  kvfe_pkg::scan_res_t res;

  // Output queue pointers and fill count
  logic [QP_W-1:0]     wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QC_W-1:0]     q_cnt_r, q_cnt_nxt;

  // Room for two words must be there before a byte is taken.
  assign in_stall = (q_cnt_r > QC_W'(QDEPTH - 2));
  assign in_acc   = in_valid && !in_stall;

  kvfe_scan #(
    .MAX_LABEL_BYTES (MAX_LABEL_BYTES)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (in_acc),
    .in_byte   (in_line_byte),
    .in_end    (in_line_end),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res       (res)
  );

  // Result words for this byte: value byte first, status last.
  kvfe_pkg::res_word_t w_val, w_st, w_first;
  logic [1:0]          push_n;
  always_comb begin
    w_val   = '{value_byte: res.val_byte, is_status: 1'b0,
                code: kvfe_pkg::ST_FOUND, run_last: !res.st_vld};
    w_st    = '{value_byte: '0, is_status: 1'b1,
                code: res.st_code, run_last: 1'b1};
    w_first = res.val_vld ? w_val : w_st;
    push_n  = in_acc ? ({1'b0, res.val_vld} + {1'b0, res.st_vld}) : 2'd0;
  end

  // Output queue
  kvfe_pkg::res_word_t q_r [QDEPTH];

  assign out_valid = (q_cnt_r != '0);
  assign pop       = out_valid && !out_stall;

  always_comb begin
    wp_nxt    = wp_r + QP_W'(push_n);
    rp_nxt    = rp_r + QP_W'(pop);
    q_cnt_nxt = q_cnt_r + QC_W'(push_n) - QC_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      q_cnt_r <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      q_cnt_r <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) q_r[wp_r] <= w_first;
    if (push_n == 2'd2) q_r[wp_r + QP_W'(1)] <= w_st;
  end

  assign out_value_byte  = q_r[rp_r].value_byte;
  assign out_is_status   = q_r[rp_r].is_status;
  assign out_status_code = q_r[rp_r].code;
  assign out_run_last    = q_r[rp_r].run_last;

  // Checks
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= QC_W'(QDEPTH))
    else $error("result queue overfilled");

  a_room_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (q_cnt_r <= QC_W'(QDEPTH - 2)))
    else $error("byte taken without room for two words");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_status) |-> out_run_last)
    else $error("status word not flagged last");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_status) |-> (out_status_code != 2'd3))
    else $error("unknown status code");

endmodule
